FILE: sv/rme_pkg.sv
// shared constants, types and the arctangent table of the euler-angle converter
`timescale 1ns / 1ps
package rme_pkg;

  // matrix entry and angle formats
  localparam int ENT_W = 16;
  localparam int CIN_W = 17;             // atan2 operand, wide enough for a negated entry
  localparam int CX_W = 28;              // cordic x/y datapath
  localparam int CZ_W = 24;              // cordic angle accumulator, 2^-20 rad
  localparam int ANG_W = 16;
  localparam int PITCH_W = 15;
  localparam int THR_W = 15;

  localparam int SQ_W = 32;              // integer square root operand
  localparam int SQ_STEPS = SQ_W / 2;

  localparam logic signed [CZ_W-1:0] ANG_HALF_PI = 24'sd1647099;
  localparam logic signed [ANG_W-1:0] ANG_LIMIT_FULL = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_LIMIT_HALF = 16'sd12868;
  localparam logic signed [ENT_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [SQ_W-1:0] ONE_SQ = 32'd268435456;

  // register indexes
  localparam logic REG_SINGULAR_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic [19:0] atan_tab(input int i);
    logic [19:0] v;
    unique case (i)
      0:  v = 20'd823550;
      1:  v = 20'd486170;
      2:  v = 20'd256879;
      3:  v = 20'd130396;
      4:  v = 20'd65451;
      5:  v = 20'd32757;
      6:  v = 20'd16383;
      7:  v = 20'd8192;
      8:  v = 20'd4096;
      9:  v = 20'd2048;
      10: v = 20'd1024;
      11: v = 20'd512;
      12: v = 20'd256;
      13: v = 20'd128;
      14: v = 20'd64;
      15: v = 20'd32;
      16: v = 20'd16;
      17: v = 20'd8;
      18: v = 20'd4;
      19: v = 20'd2;
      20: v = 20'd1;
      21: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

  // matrix entries that ride along the square-root pipeline
  typedef struct packed {
    logic signed [ENT_W-1:0] r00;
    logic signed [ENT_W-1:0] r01;
    logic signed [ENT_W-1:0] r02;
    logic signed [ENT_W-1:0] r10;
    logic signed [ENT_W-1:0] r21;
    logic signed [ENT_W-1:0] r22;
    logic signed [ENT_W-1:0] xs;       // saturated r20
  } entry_t;

endpackage

FILE: sv/rme_in_if.sv
// input transaction channel: seven matrix entries
`timescale 1ns / 1ps
interface rme_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] r00;
  logic signed [15:0] r01;
  logic signed [15:0] r02;
  logic signed [15:0] r10;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;

  modport source (output valid, r00, r01, r02, r10, r20, r21, r22, input ready);
  modport sink (input valid, r00, r01, r02, r10, r20, r21, r22, output ready);
endinterface

FILE: sv/rme_out_if.sv
// result transaction channel: euler angles and singular flag
`timescale 1ns / 1ps
interface rme_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic singular;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, singular, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, singular, output ready);
endinterface

FILE: sv/rme_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module rme_isqrt import rme_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_W-1:0]     n_in,
  output logic [SQ_W/2-1:0]   root_out
);

  logic [SQ_W-1:0] n_r    [SQ_STEPS];
  logic [SQ_W-1:0] root_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] n_prev, root_prev, trial, n_nxt, root_nxt;

    if (k == 0) begin : g_first
      assign n_prev = n_in;
      assign root_prev = '0;
    end else begin : g_next
      assign n_prev = n_r[k-1];
      assign root_prev = root_r[k-1];
    end

    always_comb begin
      trial = root_prev + BIT;
      if (n_prev >= trial) begin
        n_nxt = n_prev - trial;
        root_nxt = (root_prev >> 1) + BIT;
      end else begin
        n_nxt = n_prev;
        root_nxt = root_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign root_out = root_r[SQ_STEPS-1][SQ_W/2-1:0];

endmodule

FILE: sv/rme_cordic.sv
// pipelined vectoring cordic atan2, angle out in q2.13
`timescale 1ns / 1ps
module rme_cordic import rme_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CIN_W-1:0] y_in,
  input  logic signed [CIN_W-1:0] x_in,
  output logic signed [ANG_W-1:0] ang_out
);

  logic signed [CX_W-1:0] x_r [STEPS+1];
  logic signed [CX_W-1:0] y_r [STEPS+1];
  logic signed [CZ_W-1:0] z_r [STEPS+1];
  logic                   zero_r [STEPS+1];
  logic signed [ANG_W-1:0] ang_r;

  // scale by 2^8 and fold the left half plane
  logic signed [CX_W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [CZ_W-1:0] z_nxt;

  always_comb begin
    xs = {{(CX_W-CIN_W-8){x_in[CIN_W-1]}}, x_in, 8'b0};
    ys = {{(CX_W-CIN_W-8){y_in[CIN_W-1]}}, y_in, 8'b0};
    x_nxt = xs;
    y_nxt = ys;
    z_nxt = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_nxt = ys;
        y_nxt = -xs;
        z_nxt = ANG_HALF_PI;
      end else begin
        x_nxt = -ys;
        y_nxt = xs;
        z_nxt = -ANG_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_nxt;
      y_r[0] <= y_nxt;
      z_r[0] <= z_nxt;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [CZ_W-1:0] TAB = CZ_W'(atan_tab(i));
    logic signed [CX_W-1:0] xsh, ysh;
    assign xsh = x_r[i] >>> i;
    assign ysh = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ysh;
          y_r[i+1] <= y_r[i] - xsh;
          z_r[i+1] <= z_r[i] + TAB;
        end else begin
          x_r[i+1] <= x_r[i] - ysh;
          y_r[i+1] <= y_r[i] + xsh;
          z_r[i+1] <= z_r[i] - TAB;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // round to q2.13, ties up, then clamp to +-pi
  logic signed [CZ_W-1:0] zr;
  logic signed [CZ_W-8:0] zq;
  logic signed [ANG_W-1:0] ang_nxt;

  always_comb begin
    zr = z_r[STEPS] + CZ_W'(64);
    zq = zr[CZ_W-1:7];
    if (zero_r[STEPS]) begin
      ang_nxt = '0;
    end else if (zq > (CZ_W-7)'(ANG_LIMIT_FULL)) begin
      ang_nxt = ANG_LIMIT_FULL;
    end else if (zq < -(CZ_W-7)'(ANG_LIMIT_FULL)) begin
      ang_nxt = -ANG_LIMIT_FULL;
    end else begin
      ang_nxt = zq[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign ang_out = ang_r;

endmodule

FILE: sv/rotation_matrix_to_euler.sv
// rotation matrix to roll, pitch and yaw converter, top level
`timescale 1ns / 1ps
// Converts seven entries of a rotation matrix (signed q1.14) into roll and
// yaw in radians (signed q2.13), pitch in radians (signed q1.13) and a
// gimbal-singular flag. The block is fully pipelined and takes one matrix
// every cycle while the result channel does not stall; a result passes through
// one stage for the squares, sixteen for the square roots, CORDIC_STEPS + 2
// for the atan2 units and one output register. Back pressure on the result
// channel freezes the whole pipeline in place, so nothing is lost or
// repeated. The singular threshold register sits at byte address 0 and
// should be written only while the pipeline is empty.
module rotation_matrix_to_euler import rme_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rme_in_if.sink      in_ch,
  rme_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int COR_LAT = CORDIC_STEPS + 2;

  // config register
  logic [THR_W-1:0] thr_r;
  logic             cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[2] == REG_SINGULAR_THRESHOLD) && (cfg_paddr[1:0] == 2'b00);
  assign cfg_prdata = cfg_hit ? {{(32-THR_W){1'b0}}, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  // whole pipeline advances unless a result is stuck at the output
  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: squares and asin argument saturation
  entry_t          s1_r;
  logic [30:0]     sq0_r, sq1_r;
  logic [28:0]     xsq_r;
  logic            v1_r;
  logic signed [ENT_W-1:0] xs_nxt;
  logic signed [2*ENT_W-1:0] p0, p1, px;

  always_comb begin
    if (in_ch.r20 > ONE_Q14) begin
      xs_nxt = ONE_Q14;
    end else if (in_ch.r20 < -ONE_Q14) begin
      xs_nxt = -ONE_Q14;
    end else begin
      xs_nxt = in_ch.r20;
    end
    p0 = in_ch.r00 * in_ch.r00;
    p1 = in_ch.r10 * in_ch.r10;
    px = xs_nxt * xs_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.r00 <= in_ch.r00;
      s1_r.r01 <= in_ch.r01;
      s1_r.r02 <= in_ch.r02;
      s1_r.r10 <= in_ch.r10;
      s1_r.r21 <= in_ch.r21;
      s1_r.r22 <= in_ch.r22;
      s1_r.xs <= xs_nxt;
      sq0_r <= p0[30:0];
      sq1_r <= p1[30:0];
      xsq_r <= px[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  // square roots: sy for the singularity test, c for the asin
  logic [SQ_W-1:0]   n_sy, n_c;
  logic [SQ_W/2-1:0] sy, cr;

  assign n_sy = {1'b0, sq0_r} + {1'b0, sq1_r};
  assign n_c = ONE_SQ - {3'b0, xsq_r};

  rme_isqrt u_sqrt_sy (.clk(clk), .en(adv), .n_in(n_sy), .root_out(sy));
  rme_isqrt u_sqrt_c  (.clk(clk), .en(adv), .n_in(n_c),  .root_out(cr));

  // entries and valid travel beside the square roots
  entry_t d_r [SQ_STEPS];
  logic   dv_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[k] <= (k == 0) ? s1_r : d_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= (k == 0) ? v1_r : dv_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // five atan2 units run side by side
  entry_t e;
  logic   sing_nxt;
  logic signed [ANG_W-1:0] yaw_a, roll_n, roll_p, roll_m, asin_a;

  assign e = d_r[SQ_STEPS-1];
  assign sing_nxt = {1'b0, sy} < {{(SQ_W/2+1-THR_W){1'b0}}, thr_r};

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(adv), .y_in(CIN_W'(e.r10)), .x_in(CIN_W'(e.r00)), .ang_out(yaw_a)
  );
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(adv), .y_in(CIN_W'(e.r21)), .x_in(CIN_W'(e.r22)), .ang_out(roll_n)
  );
  // singular roll, one unit for each pitch sign
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll_p (
    .clk(clk), .en(adv), .y_in(CIN_W'(e.r01)), .x_in(CIN_W'(e.r02)), .ang_out(roll_p)
  );
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll_m (
    .clk(clk), .en(adv), .y_in(-CIN_W'(e.r01)), .x_in(-CIN_W'(e.r02)), .ang_out(roll_m)
  );
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_asin (
    .clk(clk), .en(adv), .y_in(CIN_W'(e.xs)), .x_in({1'b0, cr}), .ang_out(asin_a)
  );

  logic sc_r [COR_LAT];
  logic cv_r [COR_LAT];

  for (genvar k = 0; k < COR_LAT; k++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (adv) begin
        sc_r[k] <= (k == 0) ? sing_nxt : sc_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else if (adv) begin
        cv_r[k] <= (k == 0) ? dv_r[SQ_STEPS-1] : cv_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // output stage: pitch sign picks the singular roll
  logic                      sing_f;
  logic signed [ANG_W-1:0]   asin_c, pitch_w, roll_nxt, yaw_nxt;
  logic signed [ANG_W-1:0]   roll_r, yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic                      sing_r;

  always_comb begin
    sing_f = sc_r[COR_LAT-1];
    if (asin_a > ANG_LIMIT_HALF) begin
      asin_c = ANG_LIMIT_HALF;
    end else if (asin_a < -ANG_LIMIT_HALF) begin
      asin_c = -ANG_LIMIT_HALF;
    end else begin
      asin_c = asin_a;
    end
    pitch_w = -asin_c;
    if (!sing_f) begin
      roll_nxt = roll_n;
      yaw_nxt = yaw_a;
    end else begin
      roll_nxt = pitch_w[ANG_W-1] ? roll_m : roll_p;
      yaw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r <= roll_nxt;
      pitch_r <= pitch_w[PITCH_W-1:0];
      yaw_r <= yaw_nxt;
      sing_r <= sing_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv_r[COR_LAT-1];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.roll_angle = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle = yaw_r;
  assign out_ch.singular = sing_r;

endmodule

FILE: dv/rme_tb_if.sv
// testbench package: input and result transaction types
`timescale 1ns / 1ps
package rme_tb_pkg;
  import rme_pkg::*;

  // one input transaction
  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } matrix_t;

  // one result transaction
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic sing;
  } euler_t;
endpackage

FILE: dv/rme_checker.sv
// checker: predicts euler angles from accepted matrices and compares results
`timescale 1ns / 1ps
module rme_checker import rme_pkg::*; import rme_tb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rme_in_if.sink          in_mon,
  rme_out_if.sink         out_mon,
  input  logic [14:0]     threshold,
  output int              errors,
  output int              pending
);
  euler_t angles_due[$];
  longint signed atan_q[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
    8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0};

  function automatic longint signed floor_shr(longint signed v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic longint signed lim(longint signed v, longint signed l);
    return v > l ? l : (v < -l ? -l : v);
  endfunction

  function automatic longint signed cordic_atan2(longint signed y, longint signed x);
    longint signed z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1647099;
      end else begin
        x = -y; y = t; z = -1647099;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q[i];
      end else begin
        x -= ys; y += xs; z -= atan_q[i];
      end
    end
    return lim(floor_shr(z + 64, 7), 25736);
  endfunction

  function automatic euler_t predict_euler(matrix_t m, logic [14:0] thr);
    longint signed a, c, p, r;
    longint unsigned sy;
    euler_t e;
    sy = int_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    a = lim(longint'(m.r20), 16384);
    c = longint'(int_sqrt(64'd268435456 - a * a));
    p = lim(-lim(cordic_atan2(a, c), 12868), 12868);
    e.sing = sy < thr;
    e.pitch = p[14:0];
    if (!e.sing) begin
      e.yaw = 16'(cordic_atan2(m.r10, m.r00));
      r = cordic_atan2(m.r21, m.r22);
    end else begin
      e.yaw = 0;
      if (p < 0) r = cordic_atan2(-longint'(m.r01), -longint'(m.r02));
      else r = cordic_atan2(m.r01, m.r02);
    end
    e.roll = r[15:0];
    return e;
  endfunction

  assign pending = angles_due.size();

  always @(posedge clk) begin
    matrix_t m;
    euler_t got, want;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        m = '{in_mon.r00, in_mon.r01, in_mon.r02, in_mon.r10, in_mon.r20,
              in_mon.r21, in_mon.r22};
        angles_due.push_back(predict_euler(m, threshold));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.roll_angle, out_mon.pitch_angle, out_mon.yaw_angle,
                out_mon.singular};
        if (angles_due.size() == 0) begin
          if (errors < 10) $display("unexpected result transaction %p", got);
          errors <= errors + 1;
        end else begin
          want = angles_due.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("expected %p got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_rotation_matrix_to_euler.sv
// testbench top: stimulus, register writes, idling and verdict
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler import rme_pkg::*; import rme_tb_pkg::*;;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic [14:0] thr_model = THR_RESET;
  int errors, pending;
  int cycles = 0;
  int hold_off = 0;     // long receiver stall, counted in its own process
  bit calm = 0;         // stretch with no idling

  rme_in_if in_ch();
  rme_out_if out_ch();

  rotation_matrix_to_euler dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  rme_checker chk (
    .clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .threshold(thr_model), .errors, .pending
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("rotation_matrix_to_euler: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // register write: setup then access cycle
  task automatic write_threshold(input logic [14:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 3'd4 * REG_SINGULAR_THRESHOLD; cfg_pwdata <= {17'd0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    thr_model = v;
  endtask

  // wait for the pipeline to drain before a register write
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_matrix(input matrix_t m);
    while (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r20, in_ch.r21, in_ch.r22} <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_entry();
    case ($urandom_range(5))
      0: return 16'($urandom);                             // any value
      1: return 16'(int'($urandom_range(32768)) - 16384);  // rotation range
      2: return 16'(int'($urandom_range(8)) - 4);          // near zero
      3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      4: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      default: return 16'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // random entries, sometimes shaped like gimbal lock
  function automatic matrix_t random_matrix();
    matrix_t m;
    m = '{pick_entry(), pick_entry(), pick_entry(), pick_entry(), pick_entry(),
          pick_entry(), pick_entry()};
    if ($urandom_range(3) == 0) begin
      // gimbal lock shape: r00, r10 tiny, r20 at plus or minus one
      m.r00 = 16'(int'($urandom_range(6)) - 3);
      m.r10 = 16'(int'($urandom_range(6)) - 3);
      m.r20 = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    end
    return m;
  endfunction

  task automatic directed();
    logic signed [15:0] ext[6] = '{16'sh7fff, 16'sh8000, 16'sd16384, -16'sd16384, 16'sd0, 16'sd1};
    send_matrix('0);                                       // zero vector
    send_matrix('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}); // identity
    // singular, pitch down
    send_matrix('{16'sd0, 16'sd100, 16'sd200, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    // singular, pitch up
    send_matrix('{16'sd0, 16'sd100, -16'sd200, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    // x negative, r20 saturated
    send_matrix('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, -16'sd5});
    send_matrix('{-16'sd16384, 16'sd0, 16'sd0, -16'sd1, 16'sh8000, -16'sd1, -16'sd16384});
    for (int i = 0; i < 6; i++)
      send_matrix('{ext[i], ext[5-i], ext[(i+1)%6], ext[(i+2)%6], ext[(i+3)%6],
                    ext[(i+4)%6], ext[i]});
    send_matrix('{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff});
  endtask

  initial begin
    in_ch.valid <= 0;
    {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r20, in_ch.r21, in_ch.r22} <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    in_ch.valid <= 0;
    // several thresholds, including 0 and 16384
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_threshold(15'd0);
        1: write_threshold(15'd16384);
        2: write_threshold(15'd7);
        3: write_threshold(15'($urandom_range(16384)));
        default: write_threshold(15'd1);
      endcase
      calm = (ph == 2);
      if (ph == 1) hold_off <= 300;
      for (int n = 0; n < 150; n++) send_matrix(random_matrix());
      in_ch.valid <= 0;
      calm = 0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_matrix_to_euler: match");
    end else begin
      $display("rotation_matrix_to_euler: mismatch");
    end
    $finish;
  end
endmodule
